### rtl/core/gtm_pkg.sv
package gtm_pkg;

  // Internal width for exact products and sums before the 64-bit saturation.
  // 64-bit accumulator times 16-bit coefficient plus two guard bits.
  localparam int WIDE_W = 82;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam int BL_W        = 11;
  localparam int COEF_W      = 16;
  localparam int SCALE_W     = 16;
  localparam int MAG_W       = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int MIN_BLOCK_LENGTH = 2;

  localparam logic [BL_W-1:0]           BLOCK_LENGTH_RST = BL_W'(256);
  localparam logic signed [COEF_W-1:0]  COEF_RST         = '0;
  localparam logic [SCALE_W-1:0]        OUTPUT_SCALE_RST = SCALE_W'(512);

  localparam int ROUND_COEF  = 14;
  localparam int ROUND_SCALE = 16;

  // Real/imag clamp ahead of the scale multiply: +-2^33 already saturates
  // the scaled part for any nonzero scale.
  localparam int PRE_LIM_SHIFT = 33;
  localparam int PRE_W         = PRE_LIM_SHIFT + 2;
  localparam int SCL_W         = PRE_W + SCALE_W + 1;

  localparam int PART_LIM = 65536;
  localparam int PART_W   = 17;

  // Sum of two squares of 17-bit magnitudes; even width for the root.
  localparam int SQ_W = 34;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLOCK_LENGTH,
    REG_TWICE_COSINE,
    REG_COSINE_TERM,
    REG_SINE_TERM,
    REG_OUTPUT_SCALE
  } cfg_reg_t;

  typedef struct packed {
    logic [BL_W-1:0]          block_length;
    logic signed [COEF_W-1:0] twice_cosine;
    logic signed [COEF_W-1:0] cosine_term;
    logic signed [COEF_W-1:0] sine_term;
    logic [SCALE_W-1:0]       output_scale;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_COEF,
    BK_REAL,
    BK_SCALE,
    BK_CLAMP,
    BK_SQUARE,
    BK_ROOT,
    BK_DONE
  } back_state_t;

  // Saturate to the signed 64-bit range.
  function automatic wide_t sat64(wide_t v);
    logic [WIDE_W-64:0] hi;
    hi = v[WIDE_W-1:63];
    if ((&hi) || !(|hi)) begin
      return v;
    end else if (v[WIDE_W-1]) begin
      return wide_t'({{(WIDE_W-63){1'b1}}, 63'd0});
    end else begin
      return wide_t'({{(WIDE_W-63){1'b0}}, {63{1'b1}}});
    end
  endfunction

  // Add half (saturating), then floor shift.
  function automatic wide_t shr_round(wide_t v, int unsigned s);
    wide_t t;
    t = sat64(v + (wide_t'(1) <<< (s - 1)));
    return t >>> s;
  endfunction

  function automatic logic signed [PRE_W-1:0] pre_clamp(wide_t v);
    wide_t lim;
    lim = wide_t'(1) <<< PRE_LIM_SHIFT;
    if (v > lim) begin
      return PRE_W'(lim);
    end else if (v < -lim) begin
      return PRE_W'(-lim);
    end else begin
      return PRE_W'(v);
    end
  endfunction

  // Round the scaled product, clamp to +-65536, return the magnitude.
  function automatic logic [PART_W-1:0] part_mag(logic signed [SCL_W-1:0] p);
    logic signed [SCL_W-1:0] t;
    t = (p + $signed(SCL_W'(1) <<< (ROUND_SCALE - 1))) >>> ROUND_SCALE;
    if (t > PART_LIM || t < -PART_LIM) begin
      return PART_W'(PART_LIM);
    end else if (t < 0) begin
      return PART_W'(-t);
    end else begin
      return PART_W'(t);
    end
  endfunction

endpackage

### rtl/core/gtm_if.sv
interface gtm_sample_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface gtm_result_if ();
  logic                       valid;
  logic                       ready;
  logic [gtm_pkg::MAG_W-1:0]  magnitude;
  modport source (output valid, output magnitude, input ready);
  modport sink (input valid, input magnitude, output ready);
endinterface

interface gtm_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [gtm_pkg::CFG_INDEX_W-1:0] index;
  logic [gtm_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/goertzel_tone_magnitude_core.sv
// Goertzel single-bin tone magnitude.
//
// samples : one signed Q1.15 audio sample per item (valid/ready).
// results : one unsigned Q1.15 magnitude per block of samples (valid/ready).
// cfg     : register writes (index, data); always ready. Write only while idle.
//
// The front takes one sample per cycle, but for a block's last sample while the
// queue is full: the recursion multiply-add is combinational. On the last sample
// of a block the two accumulators move into a two-entry queue; the front starts
// the next block at once. The back works one block at a time: coefficient
// products, scaling, squares, then a 17-step square root. A result passes from
// the queue through the back's states into the output register.
// Blocks no shorter than the back's time per block run at one sample a cycle
// while results is ready; shorter blocks are paced by the back.
// Reset clears the accumulators, sample count, queue and output register, and
// loads the register defaults (block length 256, scale 512, coefficients 0).
// When results stalls, the output register holds, the back waits with the next
// magnitude, the queue fills, and samples drops ready on a block's last sample.
module goertzel_tone_magnitude_core #(
  parameter int MAX_BLOCK_LENGTH = 1024,
  parameter int SAMPLE_WIDTH     = 16,
  parameter int ACC_WIDTH        = 40
) (
  input  logic         clk,
  input  logic         rst,
  gtm_sample_if.sink   samples,
  gtm_result_if.source results,
  gtm_cfg_if.sink      cfg
);

  localparam int JOB_W = 2 * ACC_WIDTH;

  gtm_pkg::cfg_t      cfg_q;

  logic               push_valid;
  logic               push_ready;
  logic [JOB_W-1:0]   push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [JOB_W-1:0]   pop_data;

  // Register file: writes to an index past the list are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.block_length <= gtm_pkg::BLOCK_LENGTH_RST;
      cfg_q.twice_cosine <= gtm_pkg::COEF_RST;
      cfg_q.cosine_term  <= gtm_pkg::COEF_RST;
      cfg_q.sine_term    <= gtm_pkg::COEF_RST;
      cfg_q.output_scale <= gtm_pkg::OUTPUT_SCALE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        gtm_pkg::REG_BLOCK_LENGTH: cfg_q.block_length <= cfg.data[gtm_pkg::BL_W-1:0];
        gtm_pkg::REG_TWICE_COSINE: cfg_q.twice_cosine <= cfg.data;
        gtm_pkg::REG_COSINE_TERM:  cfg_q.cosine_term  <= cfg.data;
        gtm_pkg::REG_SINE_TERM:    cfg_q.sine_term    <= cfg.data;
        gtm_pkg::REG_OUTPUT_SCALE: cfg_q.output_scale <= cfg.data;
        default: ;
      endcase
    end
  end

  // Front: recursion and block counting, one sample per cycle unless a block's last sample meets a full queue.
  gtm_front #(
    .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .ACC_WIDTH        (ACC_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_q      (cfg_q),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Finished blocks waiting for the back: {q1, q2} at block end.
  gtm_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: real/imag, scaling, magnitude and output register.
  gtm_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_q     (cfg_q),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job_data  (pop_data),
    .results   (results)
  );

endmodule

### rtl/core/gtm_front.sv
module gtm_front #(
  parameter int MAX_BLOCK_LENGTH = 1024,
  parameter int SAMPLE_WIDTH     = 16,
  parameter int ACC_WIDTH        = 40
) (
  input  logic                     clk,
  input  logic                     rst,
  input  gtm_pkg::cfg_t            cfg_q,
  gtm_sample_if.sink               samples,
  output logic                     push_valid,
  input  logic                     push_ready,
  output logic [2*ACC_WIDTH-1:0]   push_data
);

  localparam int PROD_W = ACC_WIDTH + gtm_pkg::COEF_W;
  localparam int CNT_W  = $clog2(MAX_BLOCK_LENGTH);
  localparam int LEN_W  = $clog2(MAX_BLOCK_LENGTH + 1);
  localparam int CMP_W  = (LEN_W > gtm_pkg::BL_W) ? LEN_W : gtm_pkg::BL_W;
  localparam int WW     = gtm_pkg::WIDE_W;

  logic signed [ACC_WIDTH-1:0]    acc_prev;
  logic signed [ACC_WIDTH-1:0]    acc_prev2;
  logic [CNT_W-1:0]               sample_count;

  logic signed [ACC_WIDTH-1:0]    acc_prev_next;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [PROD_W-1:0]       prod;
  gtm_pkg::wide_t                 prod_w;
  gtm_pkg::wide_t                 q2_w;
  gtm_pkg::wide_t                 x_w;
  gtm_pkg::wide_t                 term;
  gtm_pkg::wide_t                 sum1;
  gtm_pkg::wide_t                 sum2;
  logic [WW-ACC_WIDTH:0]          sum2_hi;
  logic [CMP_W-1:0]               block_len;
  logic [CMP_W-1:0]               len_eff;
  logic [CMP_W-1:0]               count_inc;
  logic                           last;
  logic                           accept;

  assign x      = samples.sample;
  assign prod   = $signed(cfg_q.twice_cosine) * acc_prev;
  assign prod_w = {{(WW-PROD_W){prod[PROD_W-1]}}, prod};
  assign q2_w   = {{(WW-ACC_WIDTH){acc_prev2[ACC_WIDTH-1]}}, acc_prev2};
  assign x_w    = {{(WW-SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};

  // q0 = round(2cos * q1) - q2 + x, 64-bit saturating, then to accumulator width
  always_comb begin
    term    = gtm_pkg::shr_round(gtm_pkg::sat64(prod_w), gtm_pkg::ROUND_COEF);
    sum1    = gtm_pkg::sat64(term + gtm_pkg::sat64(-q2_w));
    sum2    = gtm_pkg::sat64(sum1 + x_w);
    sum2_hi = sum2[WW-1:ACC_WIDTH-1];
    if ((&sum2_hi) || !(|sum2_hi)) begin
      acc_prev_next = sum2[ACC_WIDTH-1:0];
    end else begin
      acc_prev_next = {sum2[WW-1], {(ACC_WIDTH-1){~sum2[WW-1]}}};
    end
  end

  // effective block length, clamped into 2 .. MAX_BLOCK_LENGTH
  always_comb begin
    block_len = CMP_W'(cfg_q.block_length);
    if (block_len < CMP_W'(gtm_pkg::MIN_BLOCK_LENGTH)) begin
      len_eff = CMP_W'(gtm_pkg::MIN_BLOCK_LENGTH);
    end else if (block_len > CMP_W'(MAX_BLOCK_LENGTH)) begin
      len_eff = CMP_W'(MAX_BLOCK_LENGTH);
    end else begin
      len_eff = block_len;
    end
  end

  assign count_inc     = CMP_W'(sample_count) + CMP_W'(1);
  assign last          = (count_inc >= len_eff);
  assign samples.ready = push_ready || !last;
  assign accept        = samples.valid && samples.ready;
  assign push_valid    = samples.valid && last;
  assign push_data     = {acc_prev_next, acc_prev};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_prev     <= '0;
      acc_prev2    <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (last) begin
        acc_prev     <= '0;
        acc_prev2    <= '0;
        sample_count <= '0;
      end else begin
        acc_prev     <= acc_prev_next;
        acc_prev2    <= acc_prev;
        sample_count <= count_inc[CNT_W-1:0];
      end
    end
  end

endmodule

### rtl/core/gtm_queue.sv
module gtm_queue #(
  parameter int DATA_W = 80
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int DEPTH = gtm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/gtm_back.sv
module gtm_back #(
  parameter int ACC_WIDTH = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gtm_pkg::cfg_t          cfg_q,
  input  logic                   job_valid,
  output logic                   job_ready,
  input  logic [2*ACC_WIDTH-1:0] job_data,
  gtm_result_if.source           results
);

  localparam int PROD_W = ACC_WIDTH + gtm_pkg::COEF_W;
  localparam int WW     = gtm_pkg::WIDE_W;
  localparam int SQ_W   = gtm_pkg::SQ_W;
  localparam int PART_W = gtm_pkg::PART_W;
  localparam int MAG_W  = gtm_pkg::MAG_W;

  gtm_pkg::back_state_t state;
  gtm_pkg::back_state_t state_next;
  logic                 load_out;

  logic signed [ACC_WIDTH-1:0]         acc_p;
  logic signed [ACC_WIDTH-1:0]         acc_r;
  logic signed [PROD_W-1:0]            prod_c;
  logic signed [PROD_W-1:0]            prod_s;
  logic signed [gtm_pkg::PRE_W-1:0]    re_pre;
  logic signed [gtm_pkg::PRE_W-1:0]    im_pre;
  logic signed [gtm_pkg::SCL_W-1:0]    prod_re;
  logic signed [gtm_pkg::SCL_W-1:0]    prod_im;
  logic [PART_W-1:0]                   mag_re;
  logic [PART_W-1:0]                   mag_im;
  logic [SQ_W-1:0]                     rem;
  logic [SQ_W-1:0]                     root;
  logic [SQ_W-1:0]                     root_bit;
  logic                                out_valid;
  logic [MAG_W-1:0]                    magnitude;

  gtm_pkg::wide_t   pc_w;
  gtm_pkg::wide_t   ps_w;
  gtm_pkg::wide_t   p_w;
  gtm_pkg::wide_t   t1;
  gtm_pkg::wide_t   re_w;
  gtm_pkg::wide_t   im_w;
  logic [SQ_W-1:0]  mr_ext;
  logic [SQ_W-1:0]  mi_ext;
  logic [SQ_W-1:0]  sq_sum;
  logic [SQ_W:0]    trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    load_out   = 1'b0;
    case (state)
      gtm_pkg::BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = gtm_pkg::BK_COEF;
        end
      end
      gtm_pkg::BK_COEF:   state_next = gtm_pkg::BK_REAL;
      gtm_pkg::BK_REAL:   state_next = gtm_pkg::BK_SCALE;
      gtm_pkg::BK_SCALE:  state_next = gtm_pkg::BK_CLAMP;
      gtm_pkg::BK_CLAMP:  state_next = gtm_pkg::BK_SQUARE;
      gtm_pkg::BK_SQUARE: state_next = gtm_pkg::BK_ROOT;
      gtm_pkg::BK_ROOT: begin
        if (root_bit[0]) begin
          state_next = gtm_pkg::BK_DONE;
        end
      end
      gtm_pkg::BK_DONE: begin
        if (!out_valid || results.ready) begin
          load_out   = 1'b1;
          state_next = gtm_pkg::BK_IDLE;
        end
      end
      default: state_next = gtm_pkg::BK_IDLE;
    endcase
  end

  // real = q1 - round(q2*cos), imag = round(q2*sin)
  always_comb begin
    pc_w = {{(WW-PROD_W){prod_c[PROD_W-1]}}, prod_c};
    ps_w = {{(WW-PROD_W){prod_s[PROD_W-1]}}, prod_s};
    p_w  = {{(WW-ACC_WIDTH){acc_p[ACC_WIDTH-1]}}, acc_p};
    t1   = gtm_pkg::shr_round(gtm_pkg::sat64(pc_w), gtm_pkg::ROUND_COEF);
    re_w = gtm_pkg::sat64(p_w + gtm_pkg::sat64(-t1));
    im_w = gtm_pkg::shr_round(gtm_pkg::sat64(ps_w), gtm_pkg::ROUND_COEF);
  end

  assign mr_ext = {{(SQ_W-PART_W){1'b0}}, mag_re};
  assign mi_ext = {{(SQ_W-PART_W){1'b0}}, mag_im};
  assign sq_sum = mr_ext * mr_ext + mi_ext * mi_ext;
  assign trial  = {1'b0, root} + {1'b0, root_bit};

  always_ff @(posedge clk) begin
    case (state)
      gtm_pkg::BK_IDLE: begin
        if (job_valid) begin
          acc_p <= job_data[2*ACC_WIDTH-1:ACC_WIDTH];
          acc_r <= job_data[ACC_WIDTH-1:0];
        end
      end
      gtm_pkg::BK_COEF: begin
        prod_c <= $signed(cfg_q.cosine_term) * acc_r;
        prod_s <= $signed(cfg_q.sine_term) * acc_r;
      end
      gtm_pkg::BK_REAL: begin
        re_pre <= gtm_pkg::pre_clamp(re_w);
        im_pre <= gtm_pkg::pre_clamp(im_w);
      end
      gtm_pkg::BK_SCALE: begin
        prod_re <= re_pre * $signed({1'b0, cfg_q.output_scale});
        prod_im <= im_pre * $signed({1'b0, cfg_q.output_scale});
      end
      gtm_pkg::BK_CLAMP: begin
        mag_re <= gtm_pkg::part_mag(prod_re);
        mag_im <= gtm_pkg::part_mag(prod_im);
      end
      gtm_pkg::BK_SQUARE: begin
        rem      <= sq_sum;
        root     <= '0;
        root_bit <= SQ_W'(1) << (SQ_W - 2);
      end
      gtm_pkg::BK_ROOT: begin
        // one result bit per cycle, restoring square root
        if ({1'b0, rem} >= trial) begin
          rem  <= rem - trial[SQ_W-1:0];
          root <= (root >> 1) + root_bit;
        end else begin
          root <= root >> 1;
        end
        root_bit <= root_bit >> 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      magnitude <= (|root[SQ_W-1:MAG_W]) ? '1 : root[MAG_W-1:0];
    end
  end

  assign results.valid     = out_valid;
  assign results.magnitude = magnitude;

endmodule

### rtl/core/gtm_checker.sv
module gtm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [gtm_pkg::MAG_W-1:0] magnitude
);

  logic out_take;

  assign out_take = out_valid && out_ready;

  // output register empty after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // empty queue after reset, so samples is ready
  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("sample not ready after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(magnitude))
    else $error("stalled result changed");

  // the back needs many cycles per block: at most two results in a row
  a_spacing: assert property (@(posedge clk) disable iff (rst)
    out_take ##1 out_take |=> !out_take)
    else $error("results too close together");

endmodule

bind goertzel_tone_magnitude_core gtm_checker u_gtm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .magnitude (results.magnitude)
);
